### sv/bmp_pkg.sv
// Shared types and constants for the BMP to RGB565 stream decoder.
package bmp_pkg;

  localparam int unsigned LenW   = 32;
  localparam int unsigned CapW   = 25;
  localparam int unsigned CoordW = 24;

  localparam logic [CapW-1:0] DefaultCap = CapW'(1024 * 1024);
  localparam logic [CapW-1:0] MaxCap     = CapW'(16777216);
  localparam logic [LenW-1:0] FileHdrLen = 32'd14;
  localparam logic [LenW-1:0] HdrEnd     = 32'd54;
  localparam logic [LenW-1:0] MinDib     = 32'd40;

  localparam logic [0:0] CfgStreamLength = 1'b0;
  localparam logic [0:0] CfgPixelCap     = 1'b1;

  localparam logic [3:0] ErrShortFile   = 4'd0;
  localparam logic [3:0] ErrSignature   = 4'd1;
  localparam logic [3:0] ErrShortInfo   = 4'd2;
  localparam logic [3:0] ErrSmallDib    = 4'd3;
  localparam logic [3:0] ErrDibPastEnd  = 4'd4;
  localparam logic [3:0] ErrOffset      = 4'd5;
  localparam logic [3:0] ErrDimensions  = 4'd6;
  localparam logic [3:0] ErrPlanes      = 4'd7;
  localparam logic [3:0] ErrBpp         = 4'd8;
  localparam logic [3:0] ErrCompression = 4'd9;
  localparam logic [3:0] ErrCap         = 4'd10;
  localparam logic [3:0] ErrTruncated   = 4'd11;
  localparam logic [3:0] ErrDeclSize    = 4'd12;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_CHK_A, PH_CHK_B, PH_CHK_C, PH_CHK_D,
    PH_GAP, PH_PIXELS, PH_PAD, PH_DONE, PH_FAILED
  } phase_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_HDR, OP_SKIP, OP_PIX, OP_PAD, OP_CHK_A, OP_CHK_B, OP_CHK_C, OP_CHK_D
  } op_t;

  typedef struct packed {
    op_t  op;
    logic restart;
    logic load_out;
  } bmp_cmd_t;

  typedef struct packed {
    logic       hdr_err;
    logic       hdr_done;
    logic       before_pix;
    logic       pix_emit;
    logic       pix_last;
    logic       row_pad;
    logic       pad_one;
    logic       chk_fail;
  } bmp_status_t;

endpackage

### sv/bmp_ctrl.sv
// Sequencer for header parse, header checks, gap skip, pixel and padding phases.
module bmp_ctrl
  import bmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_start_req,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  bmp_status_t status,
  output bmp_cmd_t    cmd
);

  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free, busy, accept;
  phase_t work;

  assign out_free = !out_valid_r || out_ready;
  assign busy     = (phase_r inside {PH_CHK_A, PH_CHK_B, PH_CHK_C, PH_CHK_D});
  assign in_ready = out_free && !busy;
  assign accept   = in_valid && in_ready;
  assign work     = in_start_req ? PH_HEADER : phase_r;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_CHK_A: phase_nxt = PH_CHK_B;
      PH_CHK_B: phase_nxt = PH_CHK_C;
      PH_CHK_C: phase_nxt = PH_CHK_D;
      PH_CHK_D: begin
        if (out_free) begin
          phase_nxt = status.chk_fail ? PH_FAILED : PH_GAP;
        end
      end
      default: begin
        if (accept) begin
          case (work)
            PH_HEADER: begin
              if (status.hdr_err) begin
                phase_nxt = PH_FAILED;
              end else if (status.hdr_done) begin
                phase_nxt = PH_CHK_A;
              end else begin
                phase_nxt = PH_HEADER;
              end
            end
            PH_GAP, PH_PIXELS: begin
              if (work == PH_GAP && status.before_pix) begin
                phase_nxt = PH_GAP;
              end else if (status.pix_emit && status.pix_last) begin
                phase_nxt = PH_DONE;
              end else if (status.row_pad) begin
                phase_nxt = PH_PAD;
              end else begin
                phase_nxt = PH_PIXELS;
              end
            end
            PH_PAD: begin
              if (status.pad_one) begin
                phase_nxt = PH_PIXELS;
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
    endcase
  end

  // commands
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.restart  = 1'b0;
    cmd.load_out = 1'b0;
    case (phase_r)
      PH_CHK_A: cmd.op = OP_CHK_A;
      PH_CHK_B: cmd.op = OP_CHK_B;
      PH_CHK_C: cmd.op = OP_CHK_C;
      PH_CHK_D: begin
        if (out_free) begin
          cmd.op       = OP_CHK_D;
          cmd.load_out = status.chk_fail;
        end
      end
      default: begin
        if (accept) begin
          cmd.restart = in_start_req;
          case (work)
            PH_HEADER: begin
              cmd.op       = OP_HDR;
              cmd.load_out = status.hdr_err;
            end
            PH_GAP: begin
              if (status.before_pix) begin
                cmd.op = OP_SKIP;
              end else begin
                cmd.op       = OP_PIX;
                cmd.load_out = status.pix_emit;
              end
            end
            PH_PIXELS: begin
              cmd.op       = OP_PIX;
              cmd.load_out = status.pix_emit;
            end
            PH_PAD:  cmd.op = OP_PAD;
            default: cmd.op = OP_NONE;
          endcase
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/bmp_dp.sv
// Header fields, check arithmetic, pixel counters and the result register.
module bmp_dp
  import bmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [7:0]        in_data_byte,
  input  bmp_cmd_t          cmd,
  output bmp_status_t       status,
  output logic              out_kind,
  output logic [15:0]       out_pixel,
  output logic [CoordW-1:0] out_column,
  output logic [CoordW-1:0] out_row,
  output logic [3:0]        out_error_code,
  output logic              out_last
);

  logic [LenW-1:0] len_r;
  logic [CapW-1:0] cap_r;

  logic [31:0] pos_r, pos_nxt, pos_eff;
  logic [31:0] decl_r, decl_nxt, off_r, off_nxt, hs_r, hs_nxt;
  logic [31:0] w_r, w_nxt, h_r, h_nxt, comp_r, comp_nxt;
  logic [15:0] planes_r, planes_nxt, bpp_r, bpp_nxt;

  logic [31:0] abs_h_r;
  logic [33:0] stride_r;
  logic [63:0] wh_r;
  logic [51:0] prod_r;
  logic        chk_bad_r;
  logic [3:0]  chk_code_r;

  logic [CoordW-1:0] col_r, col_nxt, frow_r, frow_nxt;
  logic [1:0]        bip_r, bip_nxt, pad_r, pad_nxt;
  logic [15:0]       hold_r, hold_nxt;

  logic              kind_nxt, last_nxt;
  logic [15:0]       pixel_nxt;
  logic [CoordW-1:0] column_nxt, row_nxt;
  logic [3:0]        code_nxt;

  logic        hdr_op, bpp32, hdr_err;
  logic [1:0]  hdr_sel;
  logic [3:0]  hdr_code, early_code, fin_code;
  logic        early_bad, fin_bad;
  logic [32:0] dib_end;
  logic [33:0] wb;
  logic [CapW-1:0] cap_eff;
  logic [52:0] pix_end;
  logic [1:0]  bip_inc, row_pad_len;
  logic        pix_done, col_end;
  logic [31:0] col_p1, row_p1;
  logic [CoordW-1:0] out_row_val;

  assign hdr_op  = (cmd.op == OP_HDR);
  assign pos_eff = cmd.restart ? 32'd0 : pos_r;
  assign bpp32   = (bpp_r == 16'd32);
  // byte lane within a 4-byte header field (all such fields start at 2 mod 4)
  assign hdr_sel = pos_eff[1:0] - 2'd2;

  // header byte checks
  always_comb begin
    hdr_err  = 1'b0;
    hdr_code = ErrShortFile;
    if (pos_eff == 32'd0) begin
      if (len_r < FileHdrLen) begin
        hdr_err  = 1'b1;
        hdr_code = ErrShortFile;
      end else if (in_data_byte != 8'h42) begin
        hdr_err  = 1'b1;
        hdr_code = ErrSignature;
      end
    end else if (pos_eff == 32'd1) begin
      if (in_data_byte != 8'h4D) begin
        hdr_err  = 1'b1;
        hdr_code = ErrSignature;
      end else if (len_r < HdrEnd) begin
        hdr_err  = 1'b1;
        hdr_code = ErrShortInfo;
      end
    end
  end
  assign status.hdr_err  = hdr_err;
  assign status.hdr_done = (pos_eff == HdrEnd - 32'd1);

  // first-stage checks
  assign dib_end = 33'd14 + {1'b0, hs_r};
  always_comb begin
    early_bad  = 1'b1;
    early_code = ErrSmallDib;
    if (hs_r < MinDib) begin
      early_code = ErrSmallDib;
    end else if (dib_end > {1'b0, len_r}) begin
      early_code = ErrDibPastEnd;
    end else if ({1'b0, off_r} < dib_end || off_r > len_r) begin
      early_code = ErrOffset;
    end else if (w_r[31] || w_r == 32'd0 || h_r == 32'd0) begin
      early_code = ErrDimensions;
    end else if (planes_r != 16'd1) begin
      early_code = ErrPlanes;
    end else if (bpp_r != 16'd24 && bpp_r != 16'd32) begin
      early_code = ErrBpp;
    end else if (comp_r != 32'd0) begin
      early_code = ErrCompression;
    end else begin
      early_bad = 1'b0;
    end
  end

  assign wb = bpp32 ? {w_r, 2'b00} : ({2'b00, w_r} + {1'b0, w_r, 1'b0});
  assign cap_eff = (cap_r == '0) ? DefaultCap : ((cap_r > MaxCap) ? MaxCap : cap_r);
  assign pix_end = {21'd0, off_r} + {1'b0, prod_r};

  always_comb begin
    fin_bad  = chk_bad_r;
    fin_code = chk_code_r;
    if (!chk_bad_r) begin
      if (pix_end > {21'd0, len_r}) begin
        fin_bad  = 1'b1;
        fin_code = ErrTruncated;
      end else if (decl_r != 32'd0 &&
                   ({21'd0, decl_r} < pix_end || decl_r > len_r)) begin
        fin_bad  = 1'b1;
        fin_code = ErrDeclSize;
      end
    end
  end
  assign status.chk_fail = fin_bad;

  // pixel stepping
  assign status.before_pix = (pos_r < off_r);
  assign bip_inc     = bip_r + 2'd1;
  assign pix_done    = bpp32 ? (bip_inc == 2'd0) : (bip_inc == 2'd3);
  assign col_p1      = {8'd0, col_r} + 32'd1;
  assign row_p1      = {8'd0, frow_r} + 32'd1;
  assign col_end     = (col_p1 == w_r);
  assign row_pad_len = bpp32 ? 2'd0 : w_r[1:0];
  assign status.pix_emit = (bip_r == 2'd2);
  assign status.pix_last = col_end && (row_p1 == abs_h_r);
  assign status.row_pad  = pix_done && col_end && (row_pad_len != 2'd0);
  assign status.pad_one  = (pad_r == 2'd1);
  assign out_row_val = h_r[31] ? frow_r : (abs_h_r[CoordW-1:0] - 24'd1 - frow_r);

  always_comb begin
    pos_nxt    = pos_r;
    decl_nxt   = decl_r;
    off_nxt    = off_r;
    hs_nxt     = hs_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    planes_nxt = planes_r;
    bpp_nxt    = bpp_r;
    comp_nxt   = comp_r;
    col_nxt    = col_r;
    frow_nxt   = frow_r;
    bip_nxt    = bip_r;
    pad_nxt    = pad_r;
    hold_nxt   = hold_r;
    kind_nxt   = 1'b1;
    pixel_nxt  = 16'd0;
    column_nxt = '0;
    row_nxt    = '0;
    code_nxt   = hdr_code;
    last_nxt   = 1'b0;

    if (cmd.op == OP_HDR || cmd.op == OP_SKIP || cmd.op == OP_PIX || cmd.op == OP_PAD) begin
      pos_nxt = (pos_eff == 32'hFFFF_FFFF) ? pos_eff : pos_eff + 32'd1;
    end

    if (hdr_op) begin
      if (cmd.restart) begin
        decl_nxt   = '0;
        off_nxt    = '0;
        hs_nxt     = '0;
        w_nxt      = '0;
        h_nxt      = '0;
        planes_nxt = '0;
        bpp_nxt    = '0;
        comp_nxt   = '0;
        col_nxt    = '0;
        frow_nxt   = '0;
        bip_nxt    = '0;
        pad_nxt    = '0;
        hold_nxt   = '0;
      end else begin
        if (pos_eff >= 32'd2 && pos_eff < 32'd6)
          decl_nxt[{hdr_sel, 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd10 && pos_eff < 32'd14)
          off_nxt[{hdr_sel, 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd14 && pos_eff < 32'd18)
          hs_nxt[{hdr_sel, 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd18 && pos_eff < 32'd22)
          w_nxt[{hdr_sel, 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd22 && pos_eff < 32'd26)
          h_nxt[{hdr_sel, 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd26 && pos_eff < 32'd28)
          planes_nxt[{pos_eff[0], 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd28 && pos_eff < 32'd30)
          bpp_nxt[{pos_eff[0], 3'b000} +: 8] = in_data_byte;
        if (pos_eff >= 32'd30 && pos_eff < 32'd34)
          comp_nxt[{hdr_sel, 3'b000} +: 8] = in_data_byte;
      end
    end

    if (cmd.op == OP_CHK_D) begin
      code_nxt = fin_code;
    end

    if (cmd.op == OP_PIX) begin
      case (bip_r)
        2'd0: hold_nxt[7:0]  = in_data_byte;
        2'd1: hold_nxt[15:8] = in_data_byte;
        default: hold_nxt = hold_r;
      endcase
      if (status.pix_emit) begin
        kind_nxt   = 1'b0;
        pixel_nxt  = {in_data_byte[7:3], hold_r[15:10], hold_r[7:3]};
        column_nxt = col_r;
        row_nxt    = out_row_val;
        code_nxt   = ErrShortFile;
        last_nxt   = status.pix_last;
      end
      // hold everything once the final pixel is out
      if (!(status.pix_emit && status.pix_last)) begin
        bip_nxt = pix_done ? 2'd0 : bip_inc;
        if (pix_done) begin
          if (col_end) begin
            col_nxt  = '0;
            frow_nxt = frow_r + 24'd1;
            pad_nxt  = row_pad_len;
          end else begin
            col_nxt = col_r + 24'd1;
          end
        end
      end
    end

    if (cmd.op == OP_PAD) begin
      pad_nxt = pad_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      cap_r  <= '0;
      pos_r  <= '0;
      col_r  <= '0;
      frow_r <= '0;
      bip_r  <= '0;
      pad_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == {1'b0, CfgStreamLength}) len_r <= cfg_data;
      if (cfg_we && cfg_index == {1'b0, CfgPixelCap})     cap_r <= cfg_data[CapW-1:0];
      pos_r  <= pos_nxt;
      col_r  <= col_nxt;
      frow_r <= frow_nxt;
      bip_r  <= bip_nxt;
      pad_r  <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    decl_r   <= decl_nxt;
    off_r    <= off_nxt;
    hs_r     <= hs_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    planes_r <= planes_nxt;
    bpp_r    <= bpp_nxt;
    comp_r   <= comp_nxt;
    hold_r   <= hold_nxt;
    case (cmd.op)
      OP_CHK_A: begin
        chk_bad_r  <= early_bad;
        chk_code_r <= early_code;
        abs_h_r    <= h_r[31] ? (~h_r + 32'd1) : h_r;
        stride_r   <= (wb + 34'd3) & ~34'd3;
      end
      OP_CHK_B: wh_r <= {32'd0, w_r} * {32'd0, abs_h_r};
      OP_CHK_C: begin
        if (!chk_bad_r && wh_r > {39'd0, cap_eff}) begin
          chk_bad_r  <= 1'b1;
          chk_code_r <= ErrCap;
        end
        // width and height are within the cap here whenever this product matters
        prod_r <= {25'd0, stride_r[26:0]} * {27'd0, abs_h_r[24:0]};
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_kind       <= kind_nxt;
      out_pixel      <= pixel_nxt;
      out_column     <= column_nxt;
      out_row        <= row_nxt;
      out_error_code <= code_nxt;
      out_last       <= last_nxt;
    end
  end

endmodule

### sv/bmp_stream_to_rgb565_top.sv
// Top level of the BMP byte stream to RGB565 pixel stream decoder.
// One file byte is taken per beat, at one per cycle while the result register is free:
// header bytes 0..53; after byte 53 the header checks step through CHK_A to CHK_D with
// in_ready low (a product and stride unit that is stepped by the sequencer); then gap,
// padding, alpha and color bytes. A pixel result appears on the beat after its red byte;
// an error result ends the file, and later bytes are dropped until a beat with in_start_req
// set. Write stream_length (index 0) and pixel_cap (index 1) while the block is idle.
module bmp_stream_to_rgb565_top
  import bmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_start_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [15:0]       out_pixel,
  output logic [CoordW-1:0] out_column,
  output logic [CoordW-1:0] out_row,
  output logic [3:0]        out_error_code,
  output logic              out_last
);

  bmp_cmd_t    cmd;
  bmp_status_t status;

  assign cfg_ready = 1'b1;

  bmp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  bmp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_data_byte   (in_data_byte),
    .cmd            (cmd),
    .status         (status),
    .out_kind       (out_kind),
    .out_pixel      (out_pixel),
    .out_column     (out_column),
    .out_row        (out_row),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

`ifndef SYNTHESIS
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("byte taken while result held");
  a_pixel_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> (out_error_code == ErrShortFile))
    else $error("pixel beat carries error code");
  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !out_kind) else $error("last flag on error beat");
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready)) else $error("result overwritten");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for the BMP byte stream to RGB565 pixel stream decoder.
`timescale 1ns / 100ps
module tb_top;
  import bmp_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } file_beat_t;

  typedef struct packed {
    logic              kind;
    logic [15:0]       pixel;
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic [3:0]        error_code;
    logic              last;
  } pix_result_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HEADER, S_GAP, S_PIXELS, S_PAD, S_DONE, S_FAILED
  } dec_state_t;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned SettleCycles  = 12;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [31:0]       cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_data_byte;
  logic              in_start_req;
  logic              out_valid;
  logic              out_ready;
  logic              out_kind;
  logic [15:0]       out_pixel;
  logic [CoordW-1:0] out_column;
  logic [CoordW-1:0] out_row;
  logic [3:0]        out_error_code;
  logic              out_last;

  bmp_stream_to_rgb565_top i_dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predictor copy of the decoder state
  logic [31:0] m_len, m_cap;
  logic [31:0] m_pos, m_decl, m_off, m_hdr, m_w, m_h, m_comp, m_stride;
  logic [15:0] m_planes, m_bpp;
  dec_state_t  m_state;
  logic [31:0] m_col, m_frow;
  logic [1:0]  m_bip, m_pad;
  logic [15:0] m_bg;

  file_beat_t  beat_q[$];
  pix_result_t pending_q[$];
  int          fail_cnt;
  int          idle_cnt;
  bit          stim_done;

  function automatic logic [63:0] abs_h();
    logic [31:0] mag;
    mag = m_h[31] ? (~m_h + 32'd1) : m_h;
    return 64'(mag);
  endfunction

  function automatic logic [3:0] header_verdict(output logic ok);
    logic [63:0] len, dib_end, w, h, cap, stride, pix_end;
    ok = 1'b0;
    len = 64'(m_len);
    dib_end = 64'd14 + 64'(m_hdr);
    if (m_hdr < 32'd40) return ErrSmallDib;
    if (dib_end > len) return ErrDibPastEnd;
    if (64'(m_off) < dib_end || 64'(m_off) > len) return ErrOffset;
    if (m_w[31] || m_w == 0 || m_h == 0) return ErrDimensions;
    if (m_planes != 16'd1) return ErrPlanes;
    if (m_bpp != 16'd24 && m_bpp != 16'd32) return ErrBpp;
    if (m_comp != 0) return ErrCompression;
    w = 64'(m_w);
    h = abs_h();
    cap = (m_cap == 0) ? 64'(DefaultCap) : (m_cap > 32'd16777216 ? 64'd16777216 : 64'(m_cap));
    if (w * h > cap) return ErrCap;
    stride = (w * 64'(m_bpp / 8) + 64'd3) & ~64'd3;
    pix_end = 64'(m_off) + stride * h;
    if (pix_end > len) return ErrTruncated;
    if (m_decl != 0 && (64'(m_decl) < pix_end || 64'(m_decl) > len)) return ErrDeclSize;
    m_stride = stride[31:0];
    ok = 1'b1;
    return 4'd0;
  endfunction

  task automatic raise_error(input logic [3:0] code);
    pix_result_t r;
    r = '0;
    r.kind = 1'b1;
    r.error_code = code;
    pending_q.push_back(r);
    m_state = S_FAILED;
  endtask

  task automatic grab(inout logic [31:0] f, input logic [31:0] pos, input int lo,
                      input int n, input logic [7:0] b);
    if (pos >= lo && pos < lo + n) f = f | (32'(b) << (8 * (pos - lo)));
  endtask

  task automatic clear_file();
    m_pos = 0; m_decl = 0; m_off = 0; m_hdr = 0; m_w = 0; m_h = 0;
    m_planes = 0; m_bpp = 0; m_comp = 0; m_stride = 0; m_col = 0; m_frow = 0;
    m_bip = 0; m_bg = 0; m_pad = 0;
  endtask

  task automatic decode_byte(input file_beat_t it);
    logic [31:0] pos, t, bpb, h, pad;
    logic [3:0]  code;
    logic        ok, fin;
    pix_result_t r;
    logic [2:0]  nb;
    logic [7:0]  b;
    b = it.data_byte;
    if (it.start_req) begin
      clear_file();
      m_state = S_HEADER;
    end else if (m_state inside {S_IDLE, S_DONE, S_FAILED}) begin
      return;
    end
    pos = m_pos;
    if (m_pos != 32'hFFFF_FFFF) m_pos++;
    if (m_state == S_HEADER) begin
      if (pos == 0) begin
        if (m_len < 14) begin raise_error(ErrShortFile); return; end
        if (b != "B") begin raise_error(ErrSignature); return; end
      end else if (pos == 1) begin
        if (b != "M") begin raise_error(ErrSignature); return; end
        if (m_len < 54) begin raise_error(ErrShortInfo); return; end
      end
      grab(m_decl, pos, 2, 4, b);
      grab(m_off, pos, 10, 4, b);
      grab(m_hdr, pos, 14, 4, b);
      grab(m_w, pos, 18, 4, b);
      grab(m_h, pos, 22, 4, b);
      t = 32'(m_planes); grab(t, pos, 26, 2, b); m_planes = t[15:0];
      t = 32'(m_bpp); grab(t, pos, 28, 2, b); m_bpp = t[15:0];
      grab(m_comp, pos, 30, 4, b);
      if (pos == 53) begin
        code = header_verdict(ok);
        if (!ok) raise_error(code);
        else m_state = S_GAP;
      end
      return;
    end
    if (m_state == S_GAP) begin
      if (pos < m_off) return;
      m_state = S_PIXELS;
    end
    if (m_state == S_PAD) begin
      m_pad = m_pad - 1;
      if (m_pad == 0) m_state = S_PIXELS;
      return;
    end
    bpb = 32'(m_bpp / 8);
    h = 32'(abs_h());
    if (m_bip == 0) m_bg[7:0] = b;
    else if (m_bip == 1) m_bg[15:8] = b;
    else if (m_bip == 2) begin
      fin = (m_col + 1 == m_w) && (m_frow + 1 == h);
      r.kind = 1'b0;
      r.pixel = {b[7:3], m_bg[15:10], m_bg[7:3]};
      r.column = m_col[CoordW-1:0];
      t = m_h[31] ? m_frow : h - 1 - m_frow;
      r.row = t[CoordW-1:0];
      r.error_code = 4'd0;
      r.last = fin;
      pending_q.push_back(r);
      if (fin) begin m_state = S_DONE; return; end
    end
    nb = 3'(m_bip) + 3'd1;
    m_bip = nb[1:0];
    if (32'(nb) == bpb || nb == 3'd4) begin
      m_bip = 0;
      m_col++;
      if (m_col == m_w) begin
        pad = m_stride - m_w * bpb;
        m_col = 0;
        m_frow++;
        if (pad != 0) begin m_pad = pad[1:0]; m_state = S_PAD; end
      end
    end
  endtask

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) decode_byte({in_data_byte, in_start_req});
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          {in_data_byte, in_start_req} <= beat_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap;
  pix_result_t got, want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_kind, out_pixel, out_column, out_row, out_error_code, out_last};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (got.kind != want.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind); fail_cnt++;
          end
          if (got.pixel != want.pixel) begin
            $display("%0t: pixel exp %h got %h", $time, want.pixel, got.pixel); fail_cnt++;
          end
          if (got.column != want.column) begin
            $display("%0t: column exp %0d got %0d", $time, want.column, got.column);
            fail_cnt++;
          end
          if (got.row != want.row) begin
            $display("%0t: row exp %0d got %0d", $time, want.row, got.row); fail_cnt++;
          end
          if (got.error_code != want.error_code) begin
            $display("%0t: error_code exp %0d got %0d", $time, want.error_code,
                     got.error_code);
            fail_cnt++;
          end
          if (got.last != want.last) begin
            $display("%0t: last exp %0d got %0d", $time, want.last, got.last); fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!out_ready || out_valid) out_gap <= ($urandom_range(0, 3) == 0) ?
                                                 $urandom_range(0, 6) : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else if (!(stim_done && pending_q.size() == 0)) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == 2'(CfgStreamLength)) m_len = val;
    else m_cap = {7'd0, val[24:0]};
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || in_valid || pending_q.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic s);
    beat_q.push_back({b, s});
  endtask

  task automatic push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8], 1'b0);
  endtask

  // queue one BMP file; corrupt picks which header field gets broken (0 = none)
  task automatic push_file(input int w, input int hh, input int bpp, input int gap,
                           input int corrupt, output int total);
    int stride, hdr, off, habs;
    logic [31:0] hv;
    habs = hh < 0 ? -hh : hh;
    stride = (w * (bpp / 8) + 3) & ~3;
    hdr = 40 + ((corrupt == 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
    off = 14 + hdr + gap;
    total = off + stride * habs;
    hv = hh;
    push_byte(corrupt == 1 ? 8'h42 ^ 8'($urandom_range(1, 255)) : "B", 1'b1);
    push_byte(corrupt == 2 ? 8'h58 : "M", 1'b0);
    push_le(corrupt == 3 ? total + 1 : ($urandom_range(0, 1) ? total : 0), 4);
    push_le($urandom, 4);
    push_le(corrupt == 4 ? 14 + hdr - 1 : off, 4);
    push_le(corrupt == 5 ? 32'd39 : hdr, 4);
    push_le(corrupt == 6 ? 32'h8000_0001 : w, 4);
    push_le(corrupt == 7 ? 0 : hv, 4);
    push_le(corrupt == 8 ? 2 : 1, 2);
    push_le(corrupt == 9 ? 16 : bpp, 2);
    push_le(corrupt == 10 ? 1 : 0, 4);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le($urandom, 4);
    for (int i = 54; i < total; i++) push_byte($urandom_range(0, 255), 1'b0);
  endtask

  // build the file aside, set the stream length, then release the beats
  task automatic run_file(input int w, input int hh, input int bpp, input int gap,
                          input int corrupt, input int len_adj);
    int total;
    int saved;
    file_beat_t held_q[$];
    saved = beat_q.size();
    push_file(w, hh, bpp, gap, corrupt, total);
    while (beat_q.size() > saved) held_q.push_front(beat_q.pop_back());
    write_reg(2'(CfgStreamLength), total + len_adj);
    beat_q = {beat_q, held_q};
  endtask

  int total;
  logic [31:0] cap_sel;
  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_start_req = 1'b0;
    out_ready = 1'b0;
    fail_cnt = 0;
    idle_cnt = 0;
    stim_done = 1'b0;
    m_len = 0; m_cap = 0; m_state = S_IDLE;
    clear_file();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray bytes while idle, short stream, signature, short info header
    write_reg(2'(CfgStreamLength), 32'd13);
    write_reg(2'(CfgPixelCap), 32'd0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte("B", 1'b1);
    drain();
    write_reg(2'(CfgStreamLength), 32'd53);
    push_byte("A", 1'b1);
    push_byte("B", 1'b1);
    push_byte("M", 1'b0);
    push_byte(8'h00, 1'b0);
    drain();
    // directed: each header check and every pixel format
    for (int c = 1; c <= 10; c++) begin
      write_reg(2'(CfgStreamLength), 32'hFFFF_FFFF);
      push_file(1, 1, 24, 0, c, total);
      drain();
    end
    write_reg(2'(CfgPixelCap), 32'd3);
    write_reg(2'(CfgStreamLength), 32'd1000);
    push_file(2, 2, 24, 0, 0, total); drain();
    write_reg(2'(CfgPixelCap), 32'h1FF_FFFF);
    run_file(1, 1, 24, 0, 0, -1); drain();
    run_file(3, -2, 24, 2, 0, 0); drain();
    run_file(2, 2, 32, 0, 0, 0); drain();

    // random: mostly well-formed files, some broken ones
    for (int f = 0; f < 9; f++) begin
      cap_sel = $urandom_range(0, 4) == 0 ? $urandom_range(0, 30) :
                ($urandom_range(0, 1) ? 32'd0 : 32'h1FF_FFFF);
      write_reg(2'(CfgPixelCap), cap_sel);
      run_file($urandom_range(1, 5), ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 4),
               $urandom_range(0, 1) ? 24 : 32, $urandom_range(0, 3),
               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0,
               ($urandom_range(0, 7) == 0) ? -1 : int'($urandom_range(0, 2)));
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < 3; i++) push_byte($urandom_range(0, 255), 1'b0);
      drain();
    end
    stim_done = 1'b1;
    drain();
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
